// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define PS2_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ps2 controller assertion failed");

// Concurrent assertion that is checked during reset as well.
`define PS2_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("ps2 controller assertion failed");

`endif

// ----- src/ps2kmc_pkg.sv -----
// Types and constants of the keyboard and mouse controller.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ps2kmc_pkg;

   // Host and device transfers entering the block.
   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] value;
   } req_item_type;

   // One result per accepted transfer.
   typedef struct packed {
      logic [7:0] read_value;
      logic       kbd_send_valid;
      logic       aux_send_valid;
      logic [7:0] send_byte;
      logic       irq_kbd;
      logic       irq_aux;
   } rsp_item_type;

   // Opcodes on the request channel.
   localparam logic [2:0] OP_STATUS_RD = 3'd0;
   localparam logic [2:0] OP_DATA_RD   = 3'd1;
   localparam logic [2:0] OP_CMD_WR    = 3'd2;
   localparam logic [2:0] OP_DATA_WR   = 3'd3;
   localparam logic [2:0] OP_KBD_BYTE  = 3'd4;
   localparam logic [2:0] OP_AUX_BYTE  = 3'd5;

   // Controller command bytes.
   localparam logic [7:0] CMD_RD_CFG   = 8'h20;
   localparam logic [7:0] CMD_WR_CFG   = 8'h60;
   localparam logic [7:0] CMD_SELFTEST = 8'hAA;
   localparam logic [7:0] CMD_TEST_KBD = 8'hAB;
   localparam logic [7:0] CMD_TEST_AUX = 8'hA9;
   localparam logic [7:0] CMD_KBD_EN   = 8'hAE;
   localparam logic [7:0] CMD_AUX_EN   = 8'hA8;
   localparam logic [7:0] CMD_KBD_DIS  = 8'hAD;
   localparam logic [7:0] CMD_AUX_DIS  = 8'hA7;
   localparam logic [7:0] CMD_TO_AUX   = 8'hD4;

   // Fixed reply bytes.
   localparam logic [7:0] SELFTEST_PASS = 8'h55;
   localparam logic [7:0] PORT_TEST_OK  = 8'h00;
   localparam logic [7:0] PORT_TEST_BAD = 8'h01;

   // Classes that the front end sorts transfers into.
   localparam logic [2:0] CLS_NOP       = 3'd0;
   localparam logic [2:0] CLS_STATUS_RD = 3'd1;
   localparam logic [2:0] CLS_DATA_RD   = 3'd2;
   localparam logic [2:0] CLS_CMD       = 3'd3;
   localparam logic [2:0] CLS_DATA_WR   = 3'd4;
   localparam logic [2:0] CLS_KBD_BYTE  = 3'd5;
   localparam logic [2:0] CLS_AUX_BYTE  = 3'd6;

   // Decoded command kinds.
   localparam logic [3:0] KIND_UNKNOWN  = 4'd0;
   localparam logic [3:0] KIND_RD_CFG   = 4'd1;
   localparam logic [3:0] KIND_WR_CFG   = 4'd2;
   localparam logic [3:0] KIND_SELFTEST = 4'd3;
   localparam logic [3:0] KIND_TEST_KBD = 4'd4;
   localparam logic [3:0] KIND_TEST_AUX = 4'd5;
   localparam logic [3:0] KIND_KBD_EN   = 4'd6;
   localparam logic [3:0] KIND_KBD_DIS  = 4'd7;
   localparam logic [3:0] KIND_AUX_EN   = 4'd8;
   localparam logic [3:0] KIND_AUX_DIS  = 4'd9;
   localparam logic [3:0] KIND_TO_AUX   = 4'd10;

   // Where the next host data byte goes.
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_CFG  = 2'd1;
   localparam logic [1:0] PEND_AUX  = 2'd2;

   // Configuration byte bit positions.
   localparam int CFG_KBD_IRQ = 0;
   localparam int CFG_AUX_IRQ = 1;
   localparam int CFG_KBD_DIS = 4;
   localparam int CFG_AUX_DIS = 5;

   // Register indexes on the control port.
   localparam logic CSR_KBD_PRESENT = 1'b0;
   localparam logic CSR_AUX_PRESENT = 1'b1;

   // A transfer after classification.
   typedef struct packed {
      logic [2:0] cls;
      logic [3:0] kind;
      logic [7:0] value;
   } dec_item_type;

endpackage

`default_nettype wire

// ----- src/ps2_keyboard_mouse_controller_top.sv -----
// Top level of the two-port keyboard and mouse controller.
// Depends on ps2kmc_pkg, ps2kmc_front, ps2kmc_queue and ps2kmc_back.
//
// The request channel carries host register accesses (status read, data
// read, command write, data write) and bytes arriving from the keyboard
// or aux device. Every accepted transfer yields exactly one result
// transfer on the response channel, in order. Both channels use
// valid/stall: a transfer happens on a clock edge with valid high and
// stall low.
// The front end classifies requests and pushes them into a short queue;
// the back end pops one entry per cycle while its result register is free,
// updates the controller state and loads the result register. A result
// passes through the queue and then the result register before it is
// offered. Without receiver stalls, one transfer per cycle is sustained.
// When the receiver stalls, the result register holds and the queue
// fills; once it is full the request channel is stalled.
// Synchronous reset clears the configuration byte, the output buffer and
// its flags, the pending data mode and the queue; both device-present
// registers return to one. The user must write them on the control port
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module ps2_keyboard_mouse_controller_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  ps2kmc_pkg::req_item_type req_payload,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output ps2kmc_pkg::rsp_item_type rsp_payload,
   input  wire                      csr_wr_en,
   input  wire                      csr_index,
   input  wire                      csr_wdata
);

   logic                     queue_full;
   logic                     push;
   ps2kmc_pkg::dec_item_type push_item;
   logic                     pop;
   logic                     pop_valid;
   ps2kmc_pkg::dec_item_type pop_item;

   // Device-present registers, used to answer the port test commands.
   logic kbd_present_ff;
   logic aux_present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kbd_present_ff <= 1'b1;
         aux_present_ff <= 1'b1;
      end else if (csr_wr_en) begin
         if (csr_index == ps2kmc_pkg::CSR_KBD_PRESENT) begin
            kbd_present_ff <= csr_wdata;
         end
         if (csr_index == ps2kmc_pkg::CSR_AUX_PRESENT) begin
            aux_present_ff <= csr_wdata;
         end
      end
   end

   // Request decode and flow control toward the host side.
   ps2kmc_front u_front (
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .queue_full  (queue_full),
      .push        (push),
      .push_item   (push_item)
   );

   // Decouples request acceptance from result delivery.
   ps2kmc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   // Controller state and the registered result.
   ps2kmc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (pop_valid),
      .item        (pop_item),
      .item_pop    (pop),
      .kbd_present (kbd_present_ff),
      .aux_present (aux_present_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- src/ps2kmc_front.sv -----
// Front end: takes request transfers and classifies them for the back end.
// Depends on ps2kmc_pkg.
`default_nettype none

module ps2kmc_front (
   input  wire                     req_valid,
   input  ps2kmc_pkg::req_item_type req_payload,
   output logic                    req_stall,
   input  wire                     queue_full,
   output logic                    push,
   output ps2kmc_pkg::dec_item_type push_item
);

   logic [3:0] kind;
   logic [2:0] cls;

   always_comb begin
      case (req_payload.value)
         ps2kmc_pkg::CMD_RD_CFG:   kind = ps2kmc_pkg::KIND_RD_CFG;
         ps2kmc_pkg::CMD_WR_CFG:   kind = ps2kmc_pkg::KIND_WR_CFG;
         ps2kmc_pkg::CMD_SELFTEST: kind = ps2kmc_pkg::KIND_SELFTEST;
         ps2kmc_pkg::CMD_TEST_KBD: kind = ps2kmc_pkg::KIND_TEST_KBD;
         ps2kmc_pkg::CMD_TEST_AUX: kind = ps2kmc_pkg::KIND_TEST_AUX;
         ps2kmc_pkg::CMD_KBD_EN:   kind = ps2kmc_pkg::KIND_KBD_EN;
         ps2kmc_pkg::CMD_KBD_DIS:  kind = ps2kmc_pkg::KIND_KBD_DIS;
         ps2kmc_pkg::CMD_AUX_EN:   kind = ps2kmc_pkg::KIND_AUX_EN;
         ps2kmc_pkg::CMD_AUX_DIS:  kind = ps2kmc_pkg::KIND_AUX_DIS;
         ps2kmc_pkg::CMD_TO_AUX:   kind = ps2kmc_pkg::KIND_TO_AUX;
         default:                  kind = ps2kmc_pkg::KIND_UNKNOWN;
      endcase
   end

   always_comb begin
      case (req_payload.opcode)
         ps2kmc_pkg::OP_STATUS_RD: cls = ps2kmc_pkg::CLS_STATUS_RD;
         ps2kmc_pkg::OP_DATA_RD:   cls = ps2kmc_pkg::CLS_DATA_RD;
         ps2kmc_pkg::OP_CMD_WR:    cls = ps2kmc_pkg::CLS_CMD;
         ps2kmc_pkg::OP_DATA_WR:   cls = ps2kmc_pkg::CLS_DATA_WR;
         ps2kmc_pkg::OP_KBD_BYTE:  cls = ps2kmc_pkg::CLS_KBD_BYTE;
         ps2kmc_pkg::OP_AUX_BYTE:  cls = ps2kmc_pkg::CLS_AUX_BYTE;
         default:                  cls = ps2kmc_pkg::CLS_NOP;
      endcase
   end

   assign req_stall       = queue_full;
   assign push            = req_valid & ~queue_full;
   assign push_item.cls   = cls;
   assign push_item.kind  = kind;
   assign push_item.value = req_payload.value;

endmodule

`default_nettype wire

// ----- src/ps2kmc_queue.sv -----
// Short queue of classified transfers between the front and back ends.
// Depends on ps2kmc_pkg.
`default_nettype none

module ps2kmc_queue #(
   parameter int DEPTH = 2
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  ps2kmc_pkg::dec_item_type push_item,
   output logic                     full,
   input  wire                      pop,
   output logic                     pop_valid,
   output ps2kmc_pkg::dec_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ps2kmc_pkg::dec_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- src/ps2kmc_back.sv -----
// Back end: controller state, command execution and the result register.
// Depends on ps2kmc_pkg.
`default_nettype none

module ps2kmc_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      item_valid,
   input  ps2kmc_pkg::dec_item_type item,
   output logic                     item_pop,
   input  wire                      kbd_present,
   input  wire                      aux_present,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output ps2kmc_pkg::rsp_item_type rsp_payload
);

   logic [7:0] config_ff, config_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_full_ff, out_full_in;
   logic       out_aux_ff, out_aux_in;
   logic [1:0] pend_ff, pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   ps2kmc_pkg::rsp_item_type rsp_ff, rsp_in;
   logic       take;

   // The result register frees up when it is empty or being taken.
   assign take     = item_valid & (~rsp_valid_ff | ~rsp_stall);
   assign item_pop = take;

   always_comb begin
      config_in   = config_ff;
      out_byte_in = out_byte_ff;
      out_full_in = out_full_ff;
      out_aux_in  = out_aux_ff;
      pend_in     = pend_ff;
      rsp_in      = '0;

      case (item.cls)
         ps2kmc_pkg::CLS_STATUS_RD: begin
            rsp_in.read_value = {2'b00, out_aux_ff, 4'b0000, out_full_ff};
         end
         ps2kmc_pkg::CLS_DATA_RD: begin
            rsp_in.read_value = out_byte_ff;
            out_full_in       = 1'b0;
            out_aux_in        = 1'b0;
         end
         ps2kmc_pkg::CLS_CMD: begin
            pend_in = ps2kmc_pkg::PEND_NONE;
            case (item.kind)
               ps2kmc_pkg::KIND_RD_CFG: begin
                  out_byte_in = config_ff;
                  out_full_in = 1'b1;
                  out_aux_in  = 1'b0;
               end
               ps2kmc_pkg::KIND_WR_CFG: pend_in = ps2kmc_pkg::PEND_CFG;
               ps2kmc_pkg::KIND_SELFTEST: begin
                  out_byte_in = ps2kmc_pkg::SELFTEST_PASS;
                  out_full_in = 1'b1;
                  out_aux_in  = 1'b0;
               end
               ps2kmc_pkg::KIND_TEST_KBD: begin
                  out_byte_in = kbd_present ? ps2kmc_pkg::PORT_TEST_OK
                                            : ps2kmc_pkg::PORT_TEST_BAD;
                  out_full_in = 1'b1;
                  out_aux_in  = 1'b0;
               end
               ps2kmc_pkg::KIND_TEST_AUX: begin
                  out_byte_in = aux_present ? ps2kmc_pkg::PORT_TEST_OK
                                            : ps2kmc_pkg::PORT_TEST_BAD;
                  out_full_in = 1'b1;
                  out_aux_in  = 1'b0;
               end
               ps2kmc_pkg::KIND_KBD_EN:  config_in[ps2kmc_pkg::CFG_KBD_DIS] = 1'b0;
               ps2kmc_pkg::KIND_KBD_DIS: config_in[ps2kmc_pkg::CFG_KBD_DIS] = 1'b1;
               ps2kmc_pkg::KIND_AUX_EN:  config_in[ps2kmc_pkg::CFG_AUX_DIS] = 1'b0;
               ps2kmc_pkg::KIND_AUX_DIS: config_in[ps2kmc_pkg::CFG_AUX_DIS] = 1'b1;
               ps2kmc_pkg::KIND_TO_AUX:  pend_in = ps2kmc_pkg::PEND_AUX;
               default: ;
            endcase
         end
         ps2kmc_pkg::CLS_DATA_WR: begin
            if (pend_ff == ps2kmc_pkg::PEND_CFG) begin
               config_in = item.value;
            end else if (pend_ff == ps2kmc_pkg::PEND_AUX) begin
               rsp_in.aux_send_valid = 1'b1;
               rsp_in.send_byte      = item.value;
            end else begin
               rsp_in.kbd_send_valid = 1'b1;
               rsp_in.send_byte      = item.value;
            end
            pend_in = ps2kmc_pkg::PEND_NONE;
         end
         ps2kmc_pkg::CLS_KBD_BYTE: begin
            if (!config_ff[ps2kmc_pkg::CFG_KBD_DIS] && !out_full_ff) begin
               out_byte_in    = item.value;
               out_full_in    = 1'b1;
               out_aux_in     = 1'b0;
               rsp_in.irq_kbd = config_ff[ps2kmc_pkg::CFG_KBD_IRQ];
            end
         end
         ps2kmc_pkg::CLS_AUX_BYTE: begin
            if (!config_ff[ps2kmc_pkg::CFG_AUX_DIS] && !out_full_ff) begin
               out_byte_in    = item.value;
               out_full_in    = 1'b1;
               out_aux_in     = 1'b1;
               rsp_in.irq_aux = config_ff[ps2kmc_pkg::CFG_AUX_IRQ];
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         config_ff    <= '0;
         out_byte_ff  <= '0;
         out_full_ff  <= 1'b0;
         out_aux_ff   <= 1'b0;
         pend_ff      <= ps2kmc_pkg::PEND_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            config_ff   <= config_in;
            out_byte_ff <= out_byte_in;
            out_full_ff <= out_full_in;
            out_aux_ff  <= out_aux_in;
            pend_ff     <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- src/ps2kmc_checker.sv -----
// Port-level checks of the keyboard and mouse controller, bound to its top.
// Depends on ps2kmc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ps2kmc_checker (
   input wire                      clock,
   input wire                      reset,
   input wire                      rsp_valid,
   input wire                      rsp_stall,
   input ps2kmc_pkg::rsp_item_type rsp_payload
);

   logic both_ports;
   logic irq_seen;
   logic irq_clean;

   assign both_ports = rsp_payload.kbd_send_valid & rsp_payload.aux_send_valid;
   assign irq_seen   = rsp_payload.irq_kbd | rsp_payload.irq_aux;
   assign irq_clean  = (rsp_payload.read_value == 8'h00) && !rsp_payload.kbd_send_valid
                       && !rsp_payload.aux_send_valid
                       && !(rsp_payload.irq_kbd && rsp_payload.irq_aux);

   // A stalled result stays offered and unchanged.
   `PS2_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `PS2_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_payload))

   // A host data byte goes to one device at most.
   `PS2_ASSERT(a_one_port, clock, reset, rsp_valid |-> !both_ports)

   // An interrupt pulse comes only from a device byte, so nothing else is set.
   `PS2_ASSERT(a_irq_alone, clock, reset, rsp_valid && irq_seen |-> irq_clean)

   // Nothing is offered in the cycle after reset.
   `PS2_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind ps2_keyboard_mouse_controller_top ps2kmc_checker u_ps2kmc_checker (.*);

`default_nettype wire
